// ===== hw/rtl/bple_pkg.sv =====
// ----------------------------------------------------------------------------
// bple_pkg: shared types and constants for the positional list engine
// Request codes, status codes and the front-to-back command record.
// ----------------------------------------------------------------------------
package bple_pkg;

    localparam int unsigned Capacity = 64;
    localparam int unsigned IdxW     = $clog2(Capacity);
    localparam int unsigned CntW     = $clog2(Capacity + 1);

    localparam logic [3:0] MODE_INS_HEAD = 4'd0;
    localparam logic [3:0] MODE_INS_TAIL = 4'd1;
    localparam logic [3:0] MODE_INS_POS  = 4'd2;
    localparam logic [3:0] MODE_DEL_HEAD = 4'd3;
    localparam logic [3:0] MODE_DEL_TAIL = 4'd4;
    localparam logic [3:0] MODE_DEL_POS  = 4'd5;
    localparam logic [3:0] MODE_FIND     = 4'd6;
    localparam logic [3:0] MODE_READ     = 4'd7;
    localparam logic [3:0] MODE_WRITE    = 4'd8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_FULLEMPTY = 2'd2;

    typedef enum logic [2:0] {
        t_OP_NONE,
        t_OP_INS,
        t_OP_DEL,
        t_OP_FIND,
        t_OP_READ,
        t_OP_WRITE
    } t_op;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        t_op         op;
        logic        ok;      // position check passed
        logic [1:0]  st;      // status if not ok
        logic [IdxW-1:0] at;
        logic [31:0] val;
    } t_cmd;

endpackage

// ===== hw/rtl/bounded_positional_list_engine_top.sv =====
// Path: a request beat is held in the front-end command register and then in
// the back-end result register (find registers the parallel compare and then
// the first-match encode). The length check of a request needs the length
// left by the previous one, so input waits for the result beat to leave
// before the next request is taken.
// Reset: synchronous active-low i_rst_n empties the list; cell contents are
// left as they are and never read beyond the length.
// ----------------------------------------------------------------------------
// bounded_positional_list_engine_top: ordered list of signed 32-bit values
// Insert, remove, find, read and write by position, one result per request.
// ----------------------------------------------------------------------------
module bounded_positional_list_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] mode, [10:4] position, [42:11] item_value, [47:43] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] result_value, [38:32] found_index, [45:39] list_length,
    // [47:46] status
    output logic [47:0] m_axis_tdata
);
    logic                      w_cmd_valid;
    logic                      w_cmd_ready;
    bple_pkg::t_cmd            w_cmd;
    logic [bple_pkg::CntW-1:0] w_count;
    logic                      w_busy;
    logic [31:0]               w_rv;
    logic [6:0]                w_idx;
    logic [6:0]                w_len;
    logic [1:0]                w_st;

    // front end: decode and bounds check
    bple_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_mode       (s_axis_tdata[3:0]),
        .i_position   (s_axis_tdata[10:4]),
        .i_item_value (s_axis_tdata[42:11]),
        .i_count      (w_count),
        .i_busy       (w_busy),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_ready  (w_cmd_ready)
    );

    // back end: cell row, search and result register
    bple_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_ready    (w_cmd_ready),
        .o_count        (w_count),
        .o_busy         (w_busy),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_result_value (w_rv),
        .o_found_index  (w_idx),
        .o_list_length  (w_len),
        .o_status       (w_st)
    );

    assign m_axis_tdata = {w_st, w_len, w_idx, w_rv};
endmodule

// ===== hw/rtl/bple_front.sv =====
// ----------------------------------------------------------------------------
// bple_front: request classifier
// Accepts request beats, decodes mode and checks bounds against the length.
// ----------------------------------------------------------------------------
module bple_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [3:0]                 i_mode,
    input  logic [6:0]                 i_position,
    input  logic [31:0]                i_item_value,
    input  logic [bple_pkg::CntW-1:0]  i_count,
    input  logic                       i_busy,
    output logic                       o_cmd_valid,
    output bple_pkg::t_cmd             o_cmd,
    input  logic                       i_cmd_ready
);
    bple_pkg::t_cmd n_cmd;
    bple_pkg::t_cmd r_cmd;
    logic           r_vld;
    logic [bple_pkg::CntW:0] w_cnt, w_pos;

    // One request in flight: length must settle before the next check.
    assign o_ready     = !r_vld && !i_busy;
    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;
    assign w_cnt = {1'b0, i_count};
    assign w_pos = (bple_pkg::CntW + 1)'(i_position);

    always_comb begin
        n_cmd     = '0;
        n_cmd.op  = bple_pkg::t_OP_NONE;
        n_cmd.st  = bple_pkg::ST_RANGE;
        n_cmd.val = i_item_value;
        n_cmd.at  = i_position[bple_pkg::IdxW-1:0];
        case (i_mode)
            bple_pkg::MODE_INS_HEAD, bple_pkg::MODE_INS_TAIL,
            bple_pkg::MODE_INS_POS: begin
                n_cmd.op = bple_pkg::t_OP_INS;
                if (w_cnt >= (bple_pkg::CntW + 1)'(bple_pkg::Capacity)) begin
                    n_cmd.st = bple_pkg::ST_FULLEMPTY;
                end else if (i_mode == bple_pkg::MODE_INS_HEAD) begin
                    n_cmd.ok = 1'b1;
                    n_cmd.at = '0;
                end else if (i_mode == bple_pkg::MODE_INS_TAIL) begin
                    n_cmd.ok = 1'b1;
                    n_cmd.at = i_count[bple_pkg::IdxW-1:0];
                end else if (w_pos <= w_cnt) begin
                    n_cmd.ok = 1'b1;
                end
            end
            bple_pkg::MODE_DEL_HEAD, bple_pkg::MODE_DEL_TAIL,
            bple_pkg::MODE_DEL_POS: begin
                n_cmd.op = bple_pkg::t_OP_DEL;
                if (i_count == '0) begin
                    n_cmd.st = bple_pkg::ST_FULLEMPTY;
                end else if (i_mode == bple_pkg::MODE_DEL_HEAD) begin
                    n_cmd.ok = 1'b1;
                    n_cmd.at = '0;
                end else if (i_mode == bple_pkg::MODE_DEL_TAIL) begin
                    n_cmd.ok = 1'b1;
                    n_cmd.at = bple_pkg::IdxW'(i_count - 1'b1);
                end else if (w_pos < w_cnt) begin
                    n_cmd.ok = 1'b1;
                end
            end
            bple_pkg::MODE_FIND: begin
                n_cmd.op = bple_pkg::t_OP_FIND;
                n_cmd.ok = 1'b1;
            end
            bple_pkg::MODE_READ: begin
                n_cmd.op = bple_pkg::t_OP_READ;
                n_cmd.ok = w_pos < w_cnt;
            end
            bple_pkg::MODE_WRITE: begin
                n_cmd.op = bple_pkg::t_OP_WRITE;
                n_cmd.ok = w_pos < w_cnt;
            end
            default: n_cmd.op = bple_pkg::t_OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (i_cmd_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

// ===== hw/rtl/bple_back.sv =====
// ----------------------------------------------------------------------------
// bple_back: list cell array and executor
// A row of cells that shift for insert and remove, compare in parallel for
// find; a registered first-match encode finishes a search on the next cycle.
// ----------------------------------------------------------------------------
module bple_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  bple_pkg::t_cmd             i_cmd,
    output logic                       o_cmd_ready,
    output logic [bple_pkg::CntW-1:0]  o_count,
    output logic                       o_busy,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [31:0]                o_result_value,
    output logic [6:0]                 o_found_index,
    output logic [6:0]                 o_list_length,
    output logic [1:0]                 o_status
);
    localparam int unsigned N = bple_pkg::Capacity;

    logic [31:0] r_cell [N];
    logic [bple_pkg::CntW-1:0] r_cnt;
    logic [N-1:0] r_hit;
    logic         r_srch;
    logic [31:0]  r_key;
    logic         r_vld;
    logic [31:0]  r_rv;
    logic [6:0]   r_idx;
    logic [1:0]   r_st;
    logic         w_go;
    logic [bple_pkg::IdxW-1:0] w_first;
    logic         w_any;

    assign o_cmd_ready    = !r_vld && !r_srch;
    assign w_go           = i_cmd_valid && o_cmd_ready;
    assign o_busy         = r_vld || r_srch;
    assign o_count        = r_cnt;
    assign o_valid        = r_vld;
    assign o_result_value = r_rv;
    assign o_found_index  = r_idx;
    assign o_list_length  = 7'(r_cnt);
    assign o_status       = r_st;

    always_comb begin
        w_first = '0;
        w_any   = 1'b0;
        for (int k = N - 1; k >= 0; k--) begin
            if (r_hit[k]) begin
                w_first = bple_pkg::IdxW'(k);
                w_any   = 1'b1;
            end
        end
    end

    // cells
    always_ff @(posedge i_clk) begin
        if (w_go && i_cmd.ok) begin
            for (int k = 0; k < N; k++) begin
                case (i_cmd.op)
                    bple_pkg::t_OP_INS: begin
                        if (k == int'(i_cmd.at)) r_cell[k] <= i_cmd.val;
                        else if (k > int'(i_cmd.at)) r_cell[k] <= r_cell[k-1];
                    end
                    bple_pkg::t_OP_DEL: begin
                        if (k >= int'(i_cmd.at) && k < N - 1) r_cell[k] <= r_cell[k+1];
                    end
                    bple_pkg::t_OP_WRITE: begin
                        if (k == int'(i_cmd.at)) r_cell[k] <= i_cmd.val;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_key <= i_cmd.val;
            for (int k = 0; k < N; k++) begin
                r_hit[k] <= (r_cell[k] == i_cmd.val) &&
                            (k < int'(r_cnt));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_vld  <= 1'b0;
            r_srch <= 1'b0;
        end else begin
            if (r_vld && i_ready) r_vld <= 1'b0;
            if (r_srch) begin
                r_srch <= 1'b0;
                r_vld  <= 1'b1;
            end
            if (w_go) begin
                if (i_cmd.op == bple_pkg::t_OP_FIND) r_srch <= 1'b1;
                else r_vld <= 1'b1;
                if (i_cmd.ok && i_cmd.op == bple_pkg::t_OP_INS) r_cnt <= r_cnt + 1'b1;
                if (i_cmd.ok && i_cmd.op == bple_pkg::t_OP_DEL) r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_srch) begin
            r_rv  <= w_any ? r_key : '1;
            r_idx <= w_any ? 7'(w_first) : '1;
            r_st  <= w_any ? bple_pkg::ST_OK : bple_pkg::ST_RANGE;
        end else if (w_go) begin
            if (i_cmd.ok && i_cmd.op != bple_pkg::t_OP_FIND) begin
                r_idx <= 7'(i_cmd.at);
                r_st  <= bple_pkg::ST_OK;
                case (i_cmd.op)
                    bple_pkg::t_OP_DEL, bple_pkg::t_OP_READ: r_rv <= r_cell[i_cmd.at];
                    default: r_rv <= i_cmd.val;
                endcase
            end else begin
                r_rv  <= '1;
                r_idx <= '1;
                r_st  <= (i_cmd.op == bple_pkg::t_OP_NONE) ? bple_pkg::ST_RANGE : i_cmd.st;
            end
        end
    end
endmodule
